>>> src/bgt_pkg.sv
package bgt_pkg;

    // Table geometry and field widths
    localparam int ENTRIES = 16;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 16;
    localparam int COUNT_W = 16;
    localparam int PC_W    = 16;

    // Operation codes carried on s_tuser
    typedef enum logic [3:0] {
        OP_CHECK       = 4'd0,
        OP_CHECK_TABLE = 4'd1,
        OP_ADD         = 4'd2,
        OP_REMOVE_IDX  = 4'd3,
        OP_REMOVE_ADDR = 4'd4,
        OP_REPLACE     = 4'd5,
        OP_ENABLE_IDX  = 4'd6,
        OP_ENABLE_ADDR = 4'd7,
        OP_QUERY_ADDR  = 4'd8,
        OP_QUERY_IDX   = 4'd9,
        OP_SOFT_STOP   = 4'd10
    } op_t;

    // One table entry, as held in a cell and handed down the chain
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic               enabled;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] skip;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic               we;
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] skip;
        logic               en;
        logic               chk_en;
        logic               add_ok;
        logic               repl_ok;
    } cmd_t;

    // Per-cell status returned to the top level
    typedef struct packed {
        logic match;
        logic fire;
        logic sel;
        logic sel_en;
        logic sel_cond;
    } cell_stat_t;

endpackage

>>> src/breakpoint_guard_table_top.sv
// Breakpoint guard table.
// Input channel (s_*): one transfer per operation. s_tuser carries the
// operation code; s_tdata carries the operands. Check operations compare the
// address with all valid entries at once, other operations edit or query the
// table, which stays compacted in a chain of cells (removal shifts the upper
// cells down by one).
// Result channel (m_*): exactly one result transfer per input transfer.
// The result appears in the output register on the cycle after the input
// transfer. One operation is taken per cycle while the receiver keeps taking
// results.
// When the receiver stalls, the held result stays in the output register and
// s_tready falls; input is taken again as soon as the result is taken.
// Reset (aresetn low, synchronous) empties the table, disarms the soft stop,
// clears the recorded program counter and drops m_tvalid. No clearing pass
// is needed; entry contents are only read below the fill count.
module breakpoint_guard_table_top
    import bgt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] address, [19:16] entry_index, [35:20] skip_count,
    // [36] enable_value, [37] soft_any, [53:38] current_pc, [55:54] zero
    input  logic [55:0] s_tdata,
    // [3:0] operation
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] hit, [1] found, [2] found_enabled, [3] found_conditional,
    // [4] table_full, [9:5] entries_used, [10] needs_check,
    // [26:11] break_pc, [31:27] zero
    output logic [31:0] m_tdata
);

    // Operand unpacking
    op_t                op;
    logic [ADDR_W-1:0]  in_addr;
    logic [IDX_W-1:0]   in_idx;
    logic [COUNT_W-1:0] in_skip;
    logic               in_en;
    logic               in_any;
    logic [PC_W-1:0]    in_pc;

    assign op      = op_t'(s_tuser);
    assign in_addr = s_tdata[15:0];
    assign in_idx  = s_tdata[19:16];
    assign in_skip = s_tdata[35:20];
    assign in_en   = s_tdata[36];
    assign in_any  = s_tdata[37];
    assign in_pc   = s_tdata[53:38];

    // Control state
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [ADDR_W-1:0] soft_addr_reg;
    logic              soft_armed_reg, soft_armed_next;
    logic              soft_any_reg;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    // No transfer is taken while reset is held
    logic accept;
    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Cell row
    cmd_t       cmd;
    entry_t     cell_q   [ENTRIES];
    entry_t     cell_nbr [ENTRIES];
    cell_stat_t stat     [ENTRIES];
    logic [ENTRIES:0]   rm_chain;
    logic [ENTRIES-1:0] match_v, fire_v, sel_v, sel_en_v, sel_cond_v;

    assign rm_chain[0] = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        if (i == ENTRIES - 1) begin : g_top
            assign cell_nbr[i] = cell_q[i];
        end else begin : g_mid
            assign cell_nbr[i] = cell_q[i+1];
        end

        bgt_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .valid    (CNT_W'(i) < used_reg),
            .at_index (in_idx == IDX_W'(i)),
            .at_count (used_reg == CNT_W'(i)),
            .rm_in    (rm_chain[i]),
            .nbr      (cell_nbr[i]),
            .cur      (cell_q[i]),
            .rm_out   (rm_chain[i+1]),
            .stat     (stat[i])
        );

        assign match_v[i]    = stat[i].match;
        assign fire_v[i]     = stat[i].fire;
        assign sel_v[i]      = stat[i].sel;
        assign sel_en_v[i]   = stat[i].sel_en;
        assign sel_cond_v[i] = stat[i].sel_cond;
    end

    // Global decisions
    logic addr_found;
    logic idx_valid;
    logic soft_fire;
    logic table_hit;
    logic full_flag;

    assign addr_found = |match_v;
    assign idx_valid  = {1'b0, in_idx} < used_reg;
    assign soft_fire  = (op == OP_CHECK) && soft_armed_reg
                     && (soft_any_reg || (in_addr == soft_addr_reg));

    always_comb begin
        cmd.we      = accept;
        cmd.op      = op;
        cmd.addr    = in_addr;
        cmd.skip    = in_skip;
        cmd.en      = in_en;
        cmd.chk_en  = (op == OP_CHECK_TABLE) || ((op == OP_CHECK) && !soft_fire);
        cmd.add_ok  = (op == OP_ADD) && !addr_found && (used_reg != CNT_W'(ENTRIES));
        cmd.repl_ok = (op == OP_REPLACE) && idx_valid && !addr_found;
    end

    assign table_hit = cmd.chk_en && (|fire_v);
    assign full_flag = (op == OP_ADD) && !addr_found && (used_reg == CNT_W'(ENTRIES));

    // Next control state and result word
    always_comb begin
        used_next       = used_reg;
        soft_armed_next = soft_armed_reg;
        pc_next         = pc_reg;
        if (cmd.add_ok) begin
            used_next = used_reg + 1'b1;
        end
        if (rm_chain[ENTRIES]) begin
            used_next = used_reg - 1'b1;
        end
        if (soft_fire) begin
            soft_armed_next = 1'b0;
        end
        if (op == OP_SOFT_STOP) begin
            soft_armed_next = 1'b1;
        end
        if (table_hit) begin
            pc_next = in_pc;
        end

        m_tdata_next        = '0;
        m_tdata_next[0]     = soft_fire || table_hit;
        if ((op == OP_QUERY_ADDR) || (op == OP_QUERY_IDX)) begin
            m_tdata_next[1] = |sel_v;
            m_tdata_next[2] = |sel_en_v;
            m_tdata_next[3] = |sel_cond_v;
        end
        m_tdata_next[4]     = full_flag;
        m_tdata_next[9:5]   = used_next;
        m_tdata_next[10]    = (used_next != '0) || soft_armed_next;
        m_tdata_next[26:11] = pc_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            soft_addr_reg  <= '0;
            soft_armed_reg <= 1'b0;
            soft_any_reg   <= 1'b0;
            pc_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                used_reg       <= used_next;
                soft_armed_reg <= soft_armed_next;
                pc_reg         <= pc_next;
                if (op == OP_SOFT_STOP) begin
                    soft_addr_reg <= in_addr;
                    soft_any_reg  <= in_any;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

>>> src/bgt_cell.sv
module bgt_cell
    import bgt_pkg::*;
(
    input  logic       aclk,
    input  cmd_t       cmd,
    input  logic       valid,      // position below the fill count
    input  logic       at_index,   // position equals entry_index
    input  logic       at_count,   // position equals the fill count
    input  logic       rm_in,      // an entry below this position is removed
    input  entry_t     nbr,        // contents of the next cell up
    output entry_t     cur,
    output logic       rm_out,
    output cell_stat_t stat
);

    entry_t             entry_reg;
    logic [COUNT_W-1:0] hits_inc;
    logic               match;
    logic               removed_here;

    assign cur = entry_reg;

    // Address compare and saturating hit count
    assign match    = valid && (entry_reg.addr == cmd.addr);
    assign hits_inc = (entry_reg.hits == {COUNT_W{1'b1}}) ? entry_reg.hits
                                                          : entry_reg.hits + 1'b1;

    // Removal ripples upward: this cell and all above take their neighbour
    assign removed_here = ((cmd.op == OP_REMOVE_IDX) && at_index && valid)
                       || ((cmd.op == OP_REMOVE_ADDR) && match);
    assign rm_out = rm_in || removed_here;

    // Status for hit and query reduction
    always_comb begin
        stat.match    = match;
        stat.fire     = match && entry_reg.enabled && (hits_inc > entry_reg.skip);
        stat.sel      = (cmd.op == OP_QUERY_ADDR) ? match : (at_index && valid);
        stat.sel_en   = stat.sel && entry_reg.enabled;
        stat.sel_cond = stat.sel && (entry_reg.skip != '0);
    end

    // Entry update
    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            case (cmd.op)
                OP_CHECK, OP_CHECK_TABLE: begin
                    if (cmd.chk_en && match && entry_reg.enabled) begin
                        entry_reg.hits <= hits_inc;
                    end
                end
                OP_ADD: begin
                    if (cmd.add_ok && at_count) begin
                        entry_reg.addr    <= cmd.addr;
                        entry_reg.enabled <= 1'b1;
                        entry_reg.hits    <= '0;
                        entry_reg.skip    <= cmd.skip;
                    end
                end
                OP_REMOVE_IDX, OP_REMOVE_ADDR: begin
                    if (rm_out) begin
                        entry_reg <= nbr;
                    end
                end
                OP_REPLACE: begin
                    if (cmd.repl_ok && at_index) begin
                        entry_reg.addr <= cmd.addr;
                        entry_reg.hits <= '0;
                    end
                end
                OP_ENABLE_IDX: begin
                    if (at_index && valid) begin
                        entry_reg.enabled <= cmd.en;
                    end
                end
                OP_ENABLE_ADDR: begin
                    if (match) begin
                        entry_reg.enabled <= cmd.en;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> dv/breakpoint_guard_table_top_test.sv
`timescale 1ns / 100ps

module breakpoint_guard_table_top_test;
    import bgt_pkg::*;

    // Operand fields of one input transfer, lowest bits last
    typedef struct packed {
        logic [1:0]         pad;
        logic [PC_W-1:0]    pc;
        logic               any;
        logic               en;
        logic [COUNT_W-1:0] skip;
        logic [IDX_W-1:0]   idx;
        logic [ADDR_W-1:0]  addr;
    } op_args_t;

    // Fields of one result transfer, lowest bits last
    typedef struct packed {
        logic [4:0]       pad;
        logic [PC_W-1:0]  break_pc;
        logic             needs_check;
        logic [CNT_W-1:0] entries_used;
        logic             table_full;
        logic             found_cond;
        logic             found_en;
        logic             found;
        logic             hit;
    } status_t;

    // Shadow copy of the guard table and the queue of predicted status words
    class guard_table_tracker;
        logic [ADDR_W-1:0]  slot_addr [ENTRIES];
        logic               slot_en   [ENTRIES];
        logic [COUNT_W-1:0] slot_hits [ENTRIES];
        logic [COUNT_W-1:0] slot_skip [ENTRIES];
        int                 used;
        logic [ADDR_W-1:0]  soft_addr;
        logic               soft_armed;
        logic               soft_any;
        logic [PC_W-1:0]    last_pc;
        status_t            pending_status[$];
        int                 mismatches;

        function new();
            used       = 0;
            soft_addr  = '0;
            soft_armed = 1'b0;
            soft_any   = 1'b0;
            last_pc    = '0;
            mismatches = 0;
        endfunction

        function int locate_addr(logic [ADDR_W-1:0] a);
            for (int i = 0; i < used; i++)
                if (slot_addr[i] == a) return i;
            return -1;
        endfunction

        // Remove one slot and close the gap
        function void drop_slot(int pos);
            if (pos < 0 || pos >= used) return;
            for (int j = pos; j + 1 < used; j++) begin
                slot_addr[j] = slot_addr[j+1];
                slot_en[j]   = slot_en[j+1];
                slot_hits[j] = slot_hits[j+1];
                slot_skip[j] = slot_skip[j+1];
            end
            used--;
        endfunction

        // Bump the matching enabled slot; fires once hits pass skip
        function bit count_hit(logic [ADDR_W-1:0] a);
            for (int i = 0; i < used; i++) begin
                if (slot_addr[i] == a && slot_en[i]) begin
                    if (slot_hits[i] != '1) slot_hits[i]++;
                    if (slot_hits[i] > slot_skip[i]) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_op(logic [3:0] op, op_args_t a);
            status_t s;
            int      pos;
            s   = '0;
            pos = -1;
            case (op)
                OP_CHECK, OP_CHECK_TABLE: begin
                    if (op == OP_CHECK && soft_armed && (soft_any || a.addr == soft_addr)) begin
                        soft_armed = 1'b0;
                        s.hit      = 1'b1;
                    end else if (count_hit(a.addr)) begin
                        last_pc = a.pc;
                        s.hit   = 1'b1;
                    end
                end
                OP_ADD: begin
                    if (locate_addr(a.addr) < 0) begin
                        if (used >= ENTRIES) begin
                            s.table_full = 1'b1;
                        end else begin
                            slot_addr[used] = a.addr;
                            slot_en[used]   = 1'b1;
                            slot_hits[used] = '0;
                            slot_skip[used] = a.skip;
                            used++;
                        end
                    end
                end
                OP_REMOVE_IDX: drop_slot(int'(a.idx));
                OP_REMOVE_ADDR: drop_slot(locate_addr(a.addr));
                OP_REPLACE: begin
                    if (int'(a.idx) < used && locate_addr(a.addr) < 0) begin
                        slot_addr[a.idx] = a.addr;
                        slot_hits[a.idx] = '0;
                    end
                end
                OP_ENABLE_IDX: begin
                    if (int'(a.idx) < used) slot_en[a.idx] = a.en;
                end
                OP_ENABLE_ADDR: begin
                    pos = locate_addr(a.addr);
                    if (pos >= 0) slot_en[pos] = a.en;
                end
                OP_QUERY_ADDR, OP_QUERY_IDX: begin
                    if (op == OP_QUERY_ADDR) pos = locate_addr(a.addr);
                    else if (int'(a.idx) < used) pos = int'(a.idx);
                    if (pos >= 0) begin
                        s.found      = 1'b1;
                        s.found_en   = slot_en[pos];
                        s.found_cond = (slot_skip[pos] != '0);
                    end
                end
                OP_SOFT_STOP: begin
                    soft_addr  = a.addr;
                    soft_any   = a.any;
                    soft_armed = 1'b1;
                end
                default: ;
            endcase
            s.entries_used = CNT_W'(used);
            s.needs_check  = (used != 0) || soft_armed;
            s.break_pc     = last_pc;
            pending_status.push_back(s);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_status(logic [31:0] data);
            status_t got;
            status_t want;
            got = data;
            if (pending_status.size() == 0) begin
                $error("result transfer with nothing pending: %h", data);
                mismatches++;
                return;
            end
            want = pending_status.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("found", want.found, got.found);
            compare_field("found_enabled", want.found_en, got.found_en);
            compare_field("found_conditional", want.found_cond, got.found_cond);
            compare_field("table_full", want.table_full, got.table_full);
            compare_field("entries_used", want.entries_used, got.entries_used);
            compare_field("needs_check", want.needs_check, got.needs_check);
            compare_field("break_pc", want.break_pc, got.break_pc);
            compare_field("padding", want.pad, got.pad);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    logic              idling;
    logic [ADDR_W-1:0] addr_pool [20];

    guard_table_tracker tracker = new();

    breakpoint_guard_table_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // One input transfer, after a random gap while idling; called and returns at a falling edge
    task automatic send_op(logic [3:0] op, logic [ADDR_W-1:0] addr, logic [IDX_W-1:0] idx,
                           logic [COUNT_W-1:0] skip, logic en, logic any,
                           logic [PC_W-1:0] pc);
        op_args_t a;
        int       gap;
        a      = '0;
        a.addr = addr;
        a.idx  = idx;
        a.skip = skip;
        a.en   = en;
        a.any  = any;
        a.pc   = pc;
        gap    = idling ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = a;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_op(op, a);
        @(negedge aclk);
    endtask

    // Hold the input back until every predicted result has been taken
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (tracker.pending_status.size() != 0) @(negedge aclk);
    endtask

    // One random operation; mode sets the mix (build-up, churn, check-heavy)
    task automatic send_random(int mode);
        int                 r;
        int                 p_add;
        int                 p_rem;
        int                 p_chk;
        logic [3:0]         op;
        logic [ADDR_W-1:0]  addr;
        logic [IDX_W-1:0]   idx;
        logic [COUNT_W-1:0] skip;
        case (mode)
            0:       begin p_add = 45; p_rem = 5;  p_chk = 30; end
            1:       begin p_add = 22; p_rem = 22; p_chk = 34; end
            default: begin p_add = 10; p_rem = 8;  p_chk = 60; end
        endcase

        r = $urandom_range(0, 99);
        if (r < p_add) begin
            op = OP_ADD;
        end else if (r < p_add + p_rem) begin
            op = $urandom_range(0, 1) ? OP_REMOVE_IDX : OP_REMOVE_ADDR;
        end else if (r < p_add + p_rem + p_chk) begin
            op = ($urandom_range(0, 99) < 80) ? OP_CHECK : OP_CHECK_TABLE;
        end else if ($urandom_range(0, 99) < 6) begin
            // unused codes above the soft stop
            op = OP_SOFT_STOP + 4'($urandom_range(1, 5));
        end else begin
            case ($urandom_range(0, 5))
                0:       op = OP_REPLACE;
                1:       op = OP_ENABLE_IDX;
                2:       op = OP_ENABLE_ADDR;
                3:       op = OP_QUERY_ADDR;
                4:       op = OP_QUERY_IDX;
                default: op = OP_SOFT_STOP;
            endcase
        end

        // mostly pool addresses so that matches and duplicates are common
        if ($urandom_range(0, 99) < 85) addr = addr_pool[$urandom_range(0, 19)];
        else addr = ADDR_W'($urandom());

        if (tracker.used > 0 && $urandom_range(0, 99) < 75)
            idx = IDX_W'($urandom_range(0, tracker.used - 1));
        else
            idx = IDX_W'($urandom_range(0, 15));

        r = $urandom_range(0, 99);
        if (r < 55)      skip = '0;
        else if (r < 80) skip = COUNT_W'($urandom_range(1, 3));
        else if (r < 92) skip = COUNT_W'($urandom());
        else if (r < 96) skip = '1;
        else             skip = '1 - 1'b1;

        send_op(op, addr, idx, skip, ($urandom_range(0, 99) < 70),
                ($urandom_range(0, 99) < 25), PC_W'($urandom()));
    endtask

    // Result side: random stall before each transfer while idling
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = idling ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_status(m_tdata);
            @(negedge aclk);
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int phase;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        idling   = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < 20; i++) addr_pool[i] = ADDR_W'($urandom());

        // Directed: empty table, extremes, duplicates, soft stop, replace corners
        send_op(OP_CHECK,       16'h0000, 4'd0,  16'd0,    1'b1, 1'b0, 16'h0001);
        send_op(OP_QUERY_IDX,   16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_ADD,         16'h0000, 4'd0,  16'd0,    1'b1, 1'b0, 16'h0000);
        send_op(OP_ADD,         16'hFFFF, 4'd15, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        send_op(OP_ADD,         16'h0000, 4'd0,  16'd5,    1'b0, 1'b0, 16'h0000);
        send_op(OP_CHECK,       16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'hFFFF);
        send_op(OP_CHECK_TABLE, 16'hFFFF, 4'd0,  16'd0,    1'b0, 1'b0, 16'h1234);
        send_op(OP_QUERY_ADDR,  16'hFFFF, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_QUERY_IDX,   16'h0000, 4'd15, 16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_ENABLE_IDX,  16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_CHECK,       16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h2222);
        send_op(OP_ENABLE_ADDR, 16'h0000, 4'd9,  16'd0,    1'b1, 1'b0, 16'h0000);
        send_op(OP_SOFT_STOP,   16'h0000, 4'd0,  16'd0,    1'b0, 1'b1, 16'h0000);
        send_op(OP_CHECK,       16'h5555, 4'd0,  16'd0,    1'b0, 1'b0, 16'h3333);
        send_op(OP_SOFT_STOP,   16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_CHECK_TABLE, 16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h4444);
        send_op(OP_SOFT_STOP,   16'h1111, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_CHECK,       16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h5555);
        send_op(OP_CHECK,       16'h1111, 4'd0,  16'd0,    1'b0, 1'b0, 16'h6666);
        send_op(OP_REPLACE,     16'h0000, 4'd1,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_REPLACE,     16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_REPLACE,     16'h7777, 4'd1,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_REMOVE_ADDR, 16'h9999, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_REMOVE_IDX,  16'h0000, 4'd0,  16'd0,    1'b0, 1'b0, 16'h0000);
        send_op(OP_SOFT_STOP + 4'd5, 16'hFFFF, 4'd15, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        wait_for_results();

        // Random phases; two of them run without idling on either side
        for (phase = 0; phase < 6; phase++) begin
            idling = !(phase == 2 || phase == 5);
            for (int n = 0; n < 275; n++) send_random(phase % 3);
            wait_for_results();
        end

        s_tvalid = 1'b0;
        while (tracker.pending_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_status.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
